FILE: src/assert_macros.svh
// Assertion helper macros for the priority queue RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on the rising clock edge, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/spq_pkg.sv
// Shared types, sizes and codes for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int PRIO_BITS    = 16;
	localparam int PAYLOAD_BITS = 32;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic ORDER_LARGE_FIRST = 1'b0;
	localparam logic ORDER_SMALL_FIRST = 1'b1;

	typedef struct packed {
		logic                    valid;
		logic [PRIO_BITS-1:0]    prio;
		logic [PAYLOAD_BITS-1:0] data;
	} entry_t;

	// Broadcast to every cell each cycle.
	typedef struct packed {
		logic                    enq;
		logic                    deq;
		logic                    order_mode;
		logic [PRIO_BITS-1:0]    prio;
		logic [PAYLOAD_BITS-1:0] data;
	} cell_ctrl_t;

endpackage

FILE: src/spq_cell.sv
// One storage cell of the shift-register priority queue.
// Depends on spq_pkg for entry_t and cell_ctrl_t.
`timescale 1ns / 1ps

module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  spq_pkg::entry_t    prev_entry,
	input  logic               prev_keep,
	input  spq_pkg::entry_t    next_entry,
	output spq_pkg::entry_t    cur_entry,
	output logic               keep
);

	logic                             valid_q;
	logic [spq_pkg::PRIO_BITS-1:0]    prio_q;
	logic [spq_pkg::PAYLOAD_BITS-1:0] data_q;
	logic                             good;

	// Stored entry ranks equal or ahead of the incoming one: it stays put.
	always_comb begin
		if (ctrl.order_mode == spq_pkg::ORDER_SMALL_FIRST) begin
			good = (prio_q <= ctrl.prio);
		end else begin
			good = (prio_q >= ctrl.prio);
		end
	end

	// Only the leading run of such cells stays; insertion is at the first break.
	assign keep = valid_q && good && prev_keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.deq) begin
			valid_q <= next_entry.valid;
		end else if (ctrl.enq && !keep) begin
			valid_q <= prev_keep ? 1'b1 : prev_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			prio_q <= next_entry.prio;
			data_q <= next_entry.data;
		end else if (ctrl.enq && !keep) begin
			if (prev_keep) begin
				prio_q <= ctrl.prio;
				data_q <= ctrl.data;
			end else begin
				prio_q <= prev_entry.prio;
				data_q <= prev_entry.data;
			end
		end
	end

	assign cur_entry = '{valid: valid_q, prio: prio_q, data: data_q};

endmodule

FILE: src/sorted_priority_queue.sv
// Sorted priority queue: a row of spq_cell storage cells, cell 0 is the head.
// The result is registered in the output register in the cycle after the input transfer.
// Throughput: one item per cycle while in_stall is low; every cell compares and shifts in parallel.
// Reset: all cells empty, order mode 0 (larger priority first).
// Depends on spq_pkg, spq_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_priority_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd,
	input  logic [spq_pkg::PRIO_BITS-1:0]    priority_req,
	input  logic [spq_pkg::PAYLOAD_BITS-1:0] payload,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic [spq_pkg::PRIO_BITS-1:0]    out_priority,
	output logic [spq_pkg::PAYLOAD_BITS-1:0] out_payload,
	output logic                             is_empty
);

	localparam int DEPTH = spq_pkg::QUEUE_DEPTH;

	logic                             order_mode_q;
	logic                             out_valid_q;
	logic [1:0]                       status_q;
	logic [spq_pkg::PRIO_BITS-1:0]    out_prio_q;
	logic [spq_pkg::PAYLOAD_BITS-1:0] out_data_q;
	logic                             is_empty_q;

	spq_pkg::entry_t     cur  [DEPTH];
	logic                keep [DEPTH];
	logic [DEPTH-1:0]    valid_vec;
	spq_pkg::cell_ctrl_t ctrl;
	logic                in_xfer;
	logic                full;
	logic                empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= spq_pkg::ORDER_LARGE_FIRST;
		end else if (cfg_we) begin
			order_mode_q <= cfg_wdata;
		end
	end

	// Output register frees up when it is empty or drained this cycle.
	assign in_stall = out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	assign full  = cur[DEPTH-1].valid;
	assign empty = !cur[0].valid;

	always_comb begin
		ctrl.enq        = in_xfer && (cmd == spq_pkg::CMD_ENQ) && !full;
		ctrl.deq        = in_xfer && (cmd == spq_pkg::CMD_DEQ) && !empty;
		ctrl.order_mode = order_mode_q;
		ctrl.prio       = priority_req;
		ctrl.data       = payload;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::entry_t prev_e;
		spq_pkg::entry_t next_e;
		logic            prev_k;

		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_k = 1'b1;
		end else begin : g_body
			assign prev_e = cur[i-1];
			assign prev_k = keep[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign next_e = '0;
		end else begin : g_link
			assign next_e = cur[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_entry (prev_e),
			.prev_keep  (prev_k),
			.next_entry (next_e),
			.cur_entry  (cur[i]),
			.keep       (keep[i])
		);

		assign valid_vec[i] = cur[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			if (cmd == spq_pkg::CMD_ENQ) begin
				status_q   <= full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_DONE;
				out_prio_q <= '0;
				out_data_q <= '0;
				is_empty_q <= 1'b0;
			end else if (empty) begin
				status_q   <= spq_pkg::STATUS_EMPTY;
				out_prio_q <= '0;
				out_data_q <= '0;
				is_empty_q <= 1'b1;
			end else begin
				status_q   <= spq_pkg::STATUS_DONE;
				out_prio_q <= cur[0].prio;
				out_data_q <= cur[0].data;
				is_empty_q <= !cur[1].valid;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_priority = out_prio_q;
	assign out_payload  = out_data_q;
	assign is_empty     = is_empty_q;

	// Occupied cells always form a prefix starting at the head.
	`ASSERT_ALWAYS(a_valid_prefix, clk,
		(!arst_n || ((valid_vec & (valid_vec + DEPTH'(1))) == '0)), "valid cells not a prefix")

	`ASSERT_CLK(a_enq_not_empty, clk, arst_n,
		(in_xfer && (cmd == spq_pkg::CMD_ENQ)) |=> (out_valid && !is_empty),
		"enqueue result reports empty queue")

	`ASSERT_CLK(a_deq_empty_status, clk, arst_n,
		(in_xfer && (cmd == spq_pkg::CMD_DEQ) && empty) |=>
		(status == spq_pkg::STATUS_EMPTY && is_empty && $stable(valid_vec)),
		"dequeue from empty queue mishandled")

	`ASSERT_CLK(a_full_drop, clk, arst_n,
		(in_xfer && (cmd == spq_pkg::CMD_ENQ) && full) |=>
		(status == spq_pkg::STATUS_FULL && $stable(valid_vec)),
		"enqueue to full queue changed contents")

endmodule
